FILE: sv/urlpd_pkg.sv
// Shared types and character classifiers for the URL percent decoder
`default_nettype none

package urlpd_pkg;

    // decoder mode between words of one message
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_PCT  = 2'd1,
        MODE_HIGH = 2'd2,
        MODE_DROP = 2'd3
    } mode_t;

    localparam int BYTE_W   = 8;
    localparam int NIBBLE_W = 4;

    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;

    // hex digit decode result
    typedef struct packed {
        logic                valid;
        logic [NIBBLE_W-1:0] value;
    } hex_t;

    // letters, digits, unreserved marks and reserved delimiters
    function automatic logic is_pass_char(input logic [BYTE_W-1:0] b);
        logic ok;
        ok = 1'b0;
        if (b >= 8'h61 && b <= 8'h7a) begin
            ok = 1'b1;
        end else if (b >= 8'h41 && b <= 8'h5a) begin
            ok = 1'b1;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            ok = 1'b1;
        end else begin
            case (b)
                8'h2d, 8'h2e, 8'h5f, 8'h7e,                 // - . _ ~
                8'h21, 8'h23, 8'h24, 8'h26, 8'h27,          // ! # $ & '
                8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2f,   // ( ) * + , /
                8'h3a, 8'h3b, 8'h3d, 8'h3f, 8'h40,          // : ; = ? @
                8'h5b, 8'h5d: ok = 1'b1;                    // [ ]
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    // strict hex digit, either case
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] b);
        hex_t             h;
        logic [BYTE_W-1:0] diff;
        h    = '0;
        diff = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            diff    = b - 8'h30;
            h.valid = 1'b1;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            diff    = b - 8'h57;
            h.valid = 1'b1;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            diff    = b - 8'h37;
            h.valid = 1'b1;
        end else begin
            h.valid = 1'b0;
        end
        h.value = diff[NIBBLE_W-1:0];
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: sv/url_percent_decoder.sv
// URL percent decoder: input register, byte classifier and escape merge, result register
//
// Usage: one encoded URL character per input word on s_in_byte, with s_is_last
// high on the final byte of a message. Allowed characters pass through, and
// "%XY" with two hex digits (either case) yields one decoded byte. A bad byte,
// an escape that decodes to zero, or a message ending inside an escape makes
// the message bad: later bytes are dropped and the message closes with one
// result word of m_out_byte 0, m_bad_input 1, m_end_of_message 1. Bytes
// decoded before the error were already sent; the consumer drops the message.
// A '%' and a first hex digit give no result word; neither does a dropped byte.
// Path: an accepted input word is held in the input register, decoded, and then
// registered into the result register, which drives m_valid. Throughput: one word
// per cycle while m_ready is high, set by the two-register pipe with one decode step between them.
// Backpressure: when m_ready is low the result register holds, the input
// register fills, and s_ready drops; with both registers full, s_ready follows
// m_ready combinationally.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to idle outside any escape.
`default_nettype none

module url_percent_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic [urlpd_pkg::BYTE_W-1:0]    s_in_byte,
    input  wire logic                            s_is_last,
    // result channel
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic [urlpd_pkg::BYTE_W-1:0]    m_out_byte,
    output      logic                            m_bad_input,
    output      logic                            m_end_of_message
);

    // pipeline registers
    logic                              in_valid_reg;
    logic [urlpd_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                              in_last_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [urlpd_pkg::BYTE_W-1:0]      out_byte_reg;
    logic                              out_bad_reg;
    logic                              out_end_reg;

    // decoder state
    urlpd_pkg::mode_t                  mode_reg;
    urlpd_pkg::mode_t                  mode_next;
    logic [urlpd_pkg::NIBBLE_W-1:0]    high_nibble_reg;
    logic [urlpd_pkg::NIBBLE_W-1:0]    high_nibble_next;

    // decode results
    logic                              advance;
    logic                              emit;
    logic                              fail;
    logic [urlpd_pkg::BYTE_W-1:0]      value;
    urlpd_pkg::hex_t                   hex;
    urlpd_pkg::mode_t                  mode_mid;

    // handshake: result register frees up, input register drains into it
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign m_valid          = out_valid_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_bad_input      = out_bad_reg;
    assign m_end_of_message = out_end_reg;

    // classify the held word against the current mode
    always_comb begin
        hex              = urlpd_pkg::hex_decode(in_byte_reg);
        fail             = 1'b0;
        emit             = 1'b0;
        value            = '0;
        mode_mid         = mode_reg;
        high_nibble_next = high_nibble_reg;
        case (mode_reg)
            urlpd_pkg::MODE_IDLE: begin
                if (urlpd_pkg::is_pass_char(in_byte_reg)) begin
                    emit  = 1'b1;
                    value = in_byte_reg;
                end else if (in_byte_reg == urlpd_pkg::CHAR_PERCENT) begin
                    mode_mid = urlpd_pkg::MODE_PCT;
                end else begin
                    fail = 1'b1;
                end
            end
            urlpd_pkg::MODE_PCT: begin
                if (!hex.valid) begin
                    fail = 1'b1;
                end else begin
                    high_nibble_next = hex.value;
                    mode_mid         = urlpd_pkg::MODE_HIGH;
                end
            end
            urlpd_pkg::MODE_HIGH: begin
                value = {high_nibble_reg, hex.value};
                if (!hex.valid || value == '0) begin
                    fail = 1'b1;
                end else begin
                    emit             = 1'b1;
                    mode_mid         = urlpd_pkg::MODE_IDLE;
                    high_nibble_next = '0;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase

        if (fail) begin
            mode_mid = urlpd_pkg::MODE_DROP;
        end

        // message end closes any escape or error
        mode_next = mode_mid;
        if (in_last_reg) begin
            if (mode_mid != urlpd_pkg::MODE_IDLE) begin
                emit = 1'b1;
                fail = 1'b1;
            end
            mode_next        = urlpd_pkg::MODE_IDLE;
            high_nibble_next = '0;
        end else if (fail) begin
            emit = 1'b0;
        end

        out_valid_next = out_valid_reg && !m_ready;
        if (advance) begin
            out_valid_next = in_valid_reg && emit;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= urlpd_pkg::MODE_IDLE;
            high_nibble_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            if (in_valid_reg && advance) begin
                mode_reg        <= mode_next;
                high_nibble_reg <= high_nibble_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_is_last;
        end
        if (advance && in_valid_reg && emit) begin
            out_byte_reg <= fail ? '0 : value;
            out_bad_reg  <= fail;
            out_end_reg  <= in_last_reg;
        end
    end

    // an error result always closes its message with a zero byte
    a_bad_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_bad_reg) |-> (out_end_reg && out_byte_reg == '0))
        else $error("error result without end mark or with nonzero byte");

    // a consumed last word leaves the decoder idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && advance) |=>
        (mode_reg == urlpd_pkg::MODE_IDLE && high_nibble_reg == '0))
        else $error("decoder not idle after last word");

    // no stale high nibble outside an escape
    a_idle_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == urlpd_pkg::MODE_IDLE) |-> (high_nibble_reg == '0))
        else $error("high nibble set while idle");

    // a held result stays put until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=>
        (out_valid_reg && $stable(out_byte_reg) && $stable(out_bad_reg)))
        else $error("result register changed while stalled");

endmodule

`default_nettype wire
